// File: design/knn_classifier_unit_defines.svh
// Assertion helpers used by the checker file.
`ifndef KNN_CLASSIFIER_UNIT_DEFINES_SVH
`define KNN_CLASSIFIER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define KNN_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("knn assertion failed");

// Next-cycle implication.
`define KNN_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("knn assertion failed");

`endif

// File: design/knn_pkg.sv
package knn_pkg;

  localparam int LBL_W  = 4;
  localparam int FV_W   = 8;
  localparam int NC_W   = 5;
  localparam int VL_W   = 11;
  localparam int STAT_W = 2;
  localparam int LBL_N  = 16;

  localparam logic [NC_W-1:0] NC_RST = 5'd3;
  localparam logic [VL_W-1:0] VL_RST = 11'd784;

  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_DROPPED = 2'd2;

  localparam logic REG_K   = 1'b0;
  localparam logic REG_LEN = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LOAD,
    ST_DIST,
    ST_DRAIN,
    ST_INS,
    ST_VOTE,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    CMP_EQ,
    CMP_LT,
    CMP_GT
  } cmp_e;

  typedef struct packed {
    logic clr;
    logic ins;
  } chain_ctl_t;

endpackage

// File: design/knn_cell.sv
module knn_cell import knn_pkg::*; #(
  parameter int DIST_W = 27,
  parameter int SLOT_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  chain_ctl_t        ctl_i,
  input  logic              en_i,
  input  logic [DIST_W-1:0] cand_dist_i,
  input  logic [LBL_W-1:0]  cand_lbl_i,
  input  logic [SLOT_W-1:0] cand_slot_i,
  input  logic              prev_vld_i,
  input  logic [DIST_W-1:0] prev_dist_i,
  input  logic [LBL_W-1:0]  prev_lbl_i,
  input  logic [SLOT_W-1:0] prev_slot_i,
  input  logic              prev_before_i,
  output logic              vld_o,
  output logic [DIST_W-1:0] dist_o,
  output logic [LBL_W-1:0]  lbl_o,
  output logic [SLOT_W-1:0] slot_o,
  output logic              before_o
);

  logic              vld_q;
  logic [DIST_W-1:0] dist_q;
  logic [LBL_W-1:0]  lbl_q;
  logic [SLOT_W-1:0] slot_q;

  // Equal distances: the larger label ranks first, then the later visited sample.
  assign before_o = !vld_q || (cand_dist_i < dist_q) ||
                    ((cand_dist_i == dist_q) && ({cand_lbl_i, cand_slot_i} > {lbl_q, slot_q}));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ctl_i.clr) begin
      vld_q <= 1'b0;
    end else if (ctl_i.ins && en_i) begin
      if (prev_before_i) begin
        vld_q <= prev_vld_i;
      end else if (before_o) begin
        vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ins && en_i) begin
      if (prev_before_i) begin
        dist_q <= prev_dist_i;
        lbl_q  <= prev_lbl_i;
        slot_q <= prev_slot_i;
      end else if (before_o) begin
        dist_q <= cand_dist_i;
        lbl_q  <= cand_lbl_i;
        slot_q <= cand_slot_i;
      end
    end
  end

  assign vld_o  = vld_q;
  assign dist_o = dist_q;
  assign lbl_o  = lbl_q;
  assign slot_o = slot_q;

endmodule

// File: design/knn_chain.sv
module knn_chain import knn_pkg::*; #(
  parameter int MAX_K  = 16,
  parameter int DIST_W = 27,
  parameter int SLOT_W = 8,
  parameter int KC_W   = 5
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  chain_ctl_t                   ctl_i,
  input  logic [KC_W-1:0]              k_i,
  input  logic [DIST_W-1:0]            cand_dist_i,
  input  logic [LBL_W-1:0]             cand_lbl_i,
  input  logic [SLOT_W-1:0]            cand_slot_i,
  output logic [MAX_K-1:0]             vld_o,
  output logic [MAX_K-1:0][DIST_W-1:0] dist_o,
  output logic [MAX_K-1:0][LBL_W-1:0]  lbl_o
);

  logic [MAX_K-1:0][SLOT_W-1:0] slot_w;
  logic [MAX_K-1:0]             before_w;

  for (genvar i = 0; i < MAX_K; i++) begin : g_cell
    logic              p_vld;
    logic [DIST_W-1:0] p_dist;
    logic [LBL_W-1:0]  p_lbl;
    logic [SLOT_W-1:0] p_slot;
    logic              p_before;

    if (i == 0) begin : g_head
      assign p_vld    = 1'b0;
      assign p_dist   = '0;
      assign p_lbl    = '0;
      assign p_slot   = '0;
      assign p_before = 1'b0;
    end else begin : g_body
      assign p_vld    = vld_o[i-1];
      assign p_dist   = dist_o[i-1];
      assign p_lbl    = lbl_o[i-1];
      assign p_slot   = slot_w[i-1];
      assign p_before = before_w[i-1];
    end

    knn_cell #(
      .DIST_W(DIST_W),
      .SLOT_W(SLOT_W)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl_i),
      .en_i         (int'(k_i) > i),
      .cand_dist_i  (cand_dist_i),
      .cand_lbl_i   (cand_lbl_i),
      .cand_slot_i  (cand_slot_i),
      .prev_vld_i   (p_vld),
      .prev_dist_i  (p_dist),
      .prev_lbl_i   (p_lbl),
      .prev_slot_i  (p_slot),
      .prev_before_i(p_before),
      .vld_o        (vld_o[i]),
      .dist_o       (dist_o[i]),
      .lbl_o        (lbl_o[i]),
      .slot_o       (slot_w[i]),
      .before_o     (before_w[i])
    );
  end

endmodule

// File: design/knn_classifier_unit.sv
// Channel  | Direction | Handshake            | Payload
// ---------+-----------+----------------------+------------------------------------------
// in       | in        | in_valid_i/in_stall_o | req_type, class_label, feature_value, vector_end
// out      | out       | out_valid_o/out_stall_i | predicted_label, status
// cfg      | in        | APB psel/penable     | neighbour_count @0x0, vector_length @0x4
//
// A vector element is taken whenever in_valid_i is high and in_stall_o is low. After the last
// element of a query the input stalls while the unit zeroes the rest of the query buffer,
// walks each sample once through the single read port, one feature a cycle, and then votes
// over the 16 labels; with an empty store it only zeroes the buffer. The result sits in an
// output register; a stalled earlier result extends the stall. The next request is taken
// while a result waits.
// Reset is asynchronous, active low; the sample memories are not cleared.
module knn_classifier_unit import knn_pkg::*; #(
  parameter int MAX_SAMPLES = 256,
  parameter int MAX_DIM     = 1024,
  parameter int MAX_K       = 16,
  parameter int NUM_LABELS  = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              req_type_i,
  input  logic [LBL_W-1:0]  class_label_i,
  input  logic [FV_W-1:0]   feature_value_i,
  input  logic              vector_end_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [LBL_W-1:0]  predicted_label_o,
  output logic [STAT_W-1:0] status_o
);

  localparam int SLOT_W     = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int TOT_W      = $clog2(MAX_SAMPLES + 1);
  localparam int POS_W      = $clog2(MAX_DIM + 1);
  localparam int DIM_AW     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int KC_W       = $clog2(MAX_K + 1);
  localparam int KI_W       = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int DIST_W     = $clog2(MAX_DIM * 65025 + 1);
  localparam int SMEM_DEPTH = MAX_SAMPLES * (2 ** DIM_AW);

  state_e state_q, state_d;

  logic [NC_W-1:0]   ncnt_q;
  logic [VL_W-1:0]   vlen_q;
  logic [POS_W-1:0]  eff_len;
  logic [KC_W-1:0]   eff_k;

  logic [POS_W-1:0]  pos_q, pos_nx, qlen_q;
  logic [TOT_W-1:0]  total_q;
  logic              ovf_q;
  logic              room, pos_in, in_acc, trn_end, qry_end;
  logic [LBL_W-1:0]  in_lbl;
  logic [SLOT_W-1:0] slot_w;

  logic [FV_W-1:0]   smem [SMEM_DEPTH];
  logic [FV_W-1:0]   qmem [MAX_DIM];
  logic [POS_W-1:0]  slen_mem [MAX_SAMPLES];
  logic [LBL_W-1:0]  lab_mem [MAX_SAMPLES];
  logic [FV_W-1:0]   smem_rd, qmem_rd;
  logic [POS_W-1:0]  slen_rd;
  logic [LBL_W-1:0]  lab_rd;

  logic [SLOT_W-1:0] s_q;
  logic [POS_W-1:0]  j_q, jp1_q;
  logic              p1_q, p2_q, last_s, last_j, pad_run;
  logic [FV_W-1:0]   fa, fb, diff;
  logic [15:0]       sq_q;
  logic [DIST_W-1:0] acc_q;

  chain_ctl_t                   ctl;
  logic [MAX_K-1:0]             ch_vld;
  logic [MAX_K-1:0][DIST_W-1:0] ch_dist;
  logic [MAX_K-1:0][LBL_W-1:0]  ch_lbl;

  logic [LBL_W-1:0]  lab_v_q, winner_q;
  logic [KI_W-1:0]   c_q;
  logic [KC_W-1:0]   n_q, n_nx, wn_q;
  cmp_e              cmp_q, cmp_nx;
  logic [DIST_W-1:0] win_q [MAX_K];
  logic [DIST_W-1:0] cur_q [MAX_K];
  logic [DIST_W-1:0] cur_nx [MAX_K];
  logic              hit, c_last, beats, out_load;
  logic [KI_W-1:0]   n_idx;

  logic              out_valid_q;
  logic [LBL_W-1:0]  out_lbl_q;
  logic [STAT_W-1:0] out_stat_q;

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_LEN) ? {21'b0, vlen_q} : {27'b0, ncnt_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ncnt_q <= NC_RST;
      vlen_q <= VL_RST;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_K) begin
        ncnt_q <= pwdata[NC_W-1:0];
      end else begin
        vlen_q <= pwdata[VL_W-1:0];
      end
    end
  end

  always_comb begin
    int l, k;
    l = int'(vlen_q);
    k = int'(ncnt_q);
    if (l == 0) l = 1;
    else if (l > MAX_DIM) l = MAX_DIM;
    if (k == 0) k = 1;
    else if (k > MAX_K) k = MAX_K;
    eff_len = POS_W'(l);
    eff_k   = KC_W'(k);
  end

  // Input stream
  assign in_acc  = in_valid_i && !in_stall_o;
  assign trn_end = in_acc && vector_end_i && !req_type_i;
  assign qry_end = in_acc && vector_end_i && req_type_i;
  assign room    = total_q < TOT_W'(MAX_SAMPLES);
  assign pos_in  = pos_q < eff_len;
  assign pos_nx  = pos_in ? (pos_q + POS_W'(1)) : pos_q;
  assign slot_w  = total_q[SLOT_W-1:0];
  assign in_lbl  = (int'(class_label_i) >= NUM_LABELS) ? LBL_W'(NUM_LABELS - 1)
                                                        : class_label_i;
  assign pad_run = (state_q == ST_PAD) && (j_q < eff_len);

  // Memories
  always_ff @(posedge clk_i) begin
    if (in_acc && pos_in && !req_type_i && room) begin
      smem[{slot_w, pos_q[DIM_AW-1:0]}] <= feature_value_i;
    end
    smem_rd <= smem[{s_q, j_q[DIM_AW-1:0]}];
  end

  // Store query elements, and zero the tail of the query buffer after the last query element
  always_ff @(posedge clk_i) begin
    if (in_acc && pos_in && req_type_i) begin
      qmem[pos_q[DIM_AW-1:0]] <= feature_value_i;
    end else if (pad_run) begin
      qmem[j_q[DIM_AW-1:0]] <= '0;
    end
    qmem_rd <= qmem[j_q[DIM_AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (trn_end && room) begin
      slen_mem[slot_w] <= pos_nx;
      lab_mem[slot_w]  <= in_lbl;
    end
    slen_rd <= slen_mem[s_q];
    lab_rd  <= lab_mem[s_q];
  end

  // Distance datapath; positions past a vector's own length read as zero
  assign last_j = (j_q == (eff_len - POS_W'(1)));
  assign last_s = ((TOT_W'(s_q) + TOT_W'(1)) == total_q);
  assign fa     = (jp1_q < slen_rd) ? smem_rd : '0;
  assign fb     = (jp1_q < qlen_q) ? qmem_rd : '0;
  assign diff   = (fa > fb) ? (fa - fb) : (fb - fa);

  // Vote step over one chain cell
  assign n_idx  = n_q[KI_W-1:0];
  assign hit    = ch_vld[c_q] && (ch_lbl[c_q] == lab_v_q);
  assign n_nx   = hit ? (n_q + KC_W'(1)) : n_q;
  assign c_last = ((KC_W'(c_q) + KC_W'(1)) == eff_k);

  always_comb begin
    cmp_nx = cmp_q;
    if (hit && (cmp_q == CMP_EQ) && (n_q < wn_q)) begin
      if (ch_dist[c_q] < win_q[n_idx]) cmp_nx = CMP_LT;
      else if (ch_dist[c_q] > win_q[n_idx]) cmp_nx = CMP_GT;
    end
    for (int i = 0; i < MAX_K; i++) begin
      cur_nx[i] = cur_q[i];
    end
    if (hit) cur_nx[n_idx] = ch_dist[c_q];
  end

  assign beats = (n_nx > wn_q) || ((n_nx == wn_q) && (cmp_nx == CMP_LT));

  knn_chain #(
    .MAX_K (MAX_K),
    .DIST_W(DIST_W),
    .SLOT_W(SLOT_W),
    .KC_W  (KC_W)
  ) u_chain (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .k_i        (eff_k),
    .cand_dist_i(acc_q),
    .cand_lbl_i (lab_rd),
    .cand_slot_i(s_q),
    .vld_o      (ch_vld),
    .dist_o     (ch_dist),
    .lbl_o      (ch_lbl)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (qry_end) state_d = ST_PAD;
      end
      ST_PAD: begin
        if (j_q >= eff_len) state_d = (total_q == '0) ? ST_DONE : ST_LOAD;
      end
      ST_LOAD:  state_d = ST_DIST;
      ST_DIST:  if (last_j) state_d = ST_DRAIN;
      ST_DRAIN: if (!p1_q && !p2_q) state_d = ST_INS;
      ST_INS:   state_d = last_s ? ST_VOTE : ST_LOAD;
      ST_VOTE:  if (c_last && (lab_v_q == LBL_W'(LBL_N - 1))) state_d = ST_DONE;
      ST_DONE:  if (!out_valid_q || !out_stall_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_stall_o = 1'b1;
    ctl        = '0;
    out_load   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        ctl.clr    = qry_end;
      end
      ST_INS:  ctl.ins  = 1'b1;
      ST_DONE: out_load = !out_valid_q || !out_stall_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pos_q       <= '0;
      total_q     <= '0;
      ovf_q       <= 1'b0;
      p1_q        <= 1'b0;
      p2_q        <= 1'b0;
      s_q         <= '0;
      j_q         <= '0;
      c_q         <= '0;
      lab_v_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      p1_q    <= (state_q == ST_DIST);
      p2_q    <= p1_q;
      if (in_acc) begin
        pos_q <= vector_end_i ? '0 : pos_nx;
      end
      if (trn_end) begin
        if (room) total_q <= total_q + TOT_W'(1);
        else ovf_q <= 1'b1;
      end
      case (state_q)
        ST_IDLE: begin
          s_q <= '0;
          if (qry_end) j_q <= pos_nx;
        end
        ST_PAD:  if (pad_run) j_q <= j_q + POS_W'(1);
        ST_LOAD: j_q <= '0;
        ST_DIST: j_q <= j_q + POS_W'(1);
        ST_INS: begin
          s_q     <= s_q + SLOT_W'(1);
          c_q     <= '0;
          lab_v_q <= '0;
        end
        ST_VOTE: begin
          if (c_last) begin
            c_q     <= '0;
            lab_v_q <= lab_v_q + LBL_W'(1);
          end else begin
            c_q <= c_q + KI_W'(1);
          end
        end
        default: ;
      endcase
      if (out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (qry_end) qlen_q <= pos_nx;
    jp1_q <= j_q;
    sq_q  <= {8'b0, diff} * {8'b0, diff};
    if (state_q == ST_LOAD) begin
      acc_q <= '0;
    end else if (p2_q) begin
      acc_q <= acc_q + DIST_W'(sq_q);
    end
    case (state_q)
      ST_INS: begin
        n_q      <= '0;
        cmp_q    <= CMP_EQ;
        wn_q     <= '0;
        winner_q <= '0;
      end
      ST_VOTE: begin
        if (c_last) begin
          if (beats) begin
            for (int i = 0; i < MAX_K; i++) begin
              win_q[i] <= cur_nx[i];
            end
            wn_q     <= n_nx;
            winner_q <= lab_v_q;
          end
          n_q   <= '0;
          cmp_q <= CMP_EQ;
        end else begin
          n_q   <= n_nx;
          cmp_q <= cmp_nx;
          for (int i = 0; i < MAX_K; i++) begin
            cur_q[i] <= cur_nx[i];
          end
        end
      end
      default: ;
    endcase
    if (out_load) begin
      if (total_q == '0) begin
        out_lbl_q  <= '0;
        out_stat_q <= STAT_EMPTY;
      end else begin
        out_lbl_q  <= winner_q;
        out_stat_q <= ovf_q ? STAT_DROPPED : STAT_OK;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign predicted_label_o = out_lbl_q;
  assign status_o          = out_stat_q;

endmodule

// File: design/knn_checker.sv
`include "knn_classifier_unit_defines.svh"

module knn_checker import knn_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              req_type_i,
  input logic              vector_end_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [LBL_W-1:0]  predicted_label_o,
  input logic [STAT_W-1:0] status_o
);

  // hold a stalled result
  `KNN_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(predicted_label_o) && $stable(status_o))
  // an empty store always reports label zero
  `KNN_ASSERT_NOW(a_empty_label, out_valid_o && (status_o == STAT_EMPTY), predicted_label_o == '0)
  // a finished query request keeps the input stalled
  `KNN_ASSERT_NEXT(a_query_busy, in_valid_i && !in_stall_o && req_type_i && vector_end_i, in_stall_o)
  // a new result follows a busy cycle
  `KNN_ASSERT_NOW(a_result_after_busy, $rose(out_valid_o), $past(in_stall_o))

endmodule

bind knn_classifier_unit knn_checker u_knn_checker (.*);
